// ----- rtl/mbgs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mirrored-border grid sampler - shared package
// Field widths, register map, configuration record and pipeline sizing.
// ----------------------------------------------------------------------------
package mbgs_pkg;

    localparam int CFG_W   = 13;              // configuration register width
    localparam int CELL_W  = 6;               // grid column / row width
    localparam int XY_W    = 12;              // frame_x / frame_y width
    localparam int IDX_W   = 24;              // pixel_index width
    localparam int PROD_W  = CELL_W + 1 + CFG_W;  // (2*cell+1) * canvas
    localparam int PER_W   = CFG_W + 1;       // mirror period 2*(n-1)
    localparam int OFF_W   = CFG_W + 1;       // signed centring offset
    localparam int VAL_W   = PROD_W + 1;      // signed coordinate before mirroring
    localparam int MAG_W   = PROD_W;          // magnitude of that coordinate
    localparam int MOD_BPS = 2;               // remainder bits resolved per stage
    localparam int MOD_STAGES = (MAG_W + MOD_BPS - 1) / MOD_BPS;
    localparam int MOD_TW  = MOD_STAGES * MOD_BPS;
    localparam int MUL2_W  = 2 * CFG_W;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_CANVAS_W = 2'd0;
    localparam logic [1:0] REG_CANVAS_H = 2'd1;
    localparam logic [1:0] REG_FRAME_W  = 2'd2;
    localparam logic [1:0] REG_FRAME_H  = 2'd3;

    localparam logic [CFG_W-1:0] RST_CANVAS_W = 13'd800;
    localparam logic [CFG_W-1:0] RST_CANVAS_H = 13'd600;
    localparam logic [CFG_W-1:0] RST_FRAME_W  = 13'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_H  = 13'd480;

    typedef struct packed {
        logic [CFG_W-1:0] canvas_w;
        logic [CFG_W-1:0] canvas_h;
        logic [CFG_W-1:0] frame_w;
        logic [CFG_W-1:0] frame_h;
    } t_cfg;

endpackage
`default_nettype wire

// ----- rtl/mbgs_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mirrored-border grid sampler - configuration registers
// APB register file for canvas and frame sizes, clamped to MAX_DIM on write.
// ----------------------------------------------------------------------------
module mbgs_cfg #(
    parameter int MAX_DIM = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [mbgs_pkg::ADDR_W-1:0]   paddr,
    input  wire  [mbgs_pkg::DATA_W-1:0]   pwdata,
    output logic [mbgs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mbgs_pkg::t_cfg                o_cfg
);

    mbgs_pkg::t_cfg                  r_cfg;
    logic                            w_wr;
    logic [1:0]                      w_sel;
    logic [mbgs_pkg::CFG_W-1:0]      w_val;
    logic [mbgs_pkg::CFG_W-1:0]      w_clamp;
    logic [mbgs_pkg::CFG_W-1:0]      w_rd;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite & pready;
    assign w_sel   = paddr[3:2];
    assign w_val   = pwdata[mbgs_pkg::CFG_W-1:0];
    assign w_clamp = (int'(w_val) > MAX_DIM) ? mbgs_pkg::CFG_W'(MAX_DIM) : w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_w <= mbgs_pkg::RST_CANVAS_W;
            r_cfg.canvas_h <= mbgs_pkg::RST_CANVAS_H;
            r_cfg.frame_w  <= mbgs_pkg::RST_FRAME_W;
            r_cfg.frame_h  <= mbgs_pkg::RST_FRAME_H;
        end else if (w_wr) begin
            unique case (w_sel)
                mbgs_pkg::REG_CANVAS_W: r_cfg.canvas_w <= w_clamp;
                mbgs_pkg::REG_CANVAS_H: r_cfg.canvas_h <= w_clamp;
                mbgs_pkg::REG_FRAME_W:  r_cfg.frame_w  <= w_clamp;
                mbgs_pkg::REG_FRAME_H:  r_cfg.frame_h  <= w_clamp;
                default:                r_cfg.frame_h  <= r_cfg.frame_h;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            mbgs_pkg::REG_CANVAS_W: w_rd = r_cfg.canvas_w;
            mbgs_pkg::REG_CANVAS_H: w_rd = r_cfg.canvas_h;
            mbgs_pkg::REG_FRAME_W:  w_rd = r_cfg.frame_w;
            mbgs_pkg::REG_FRAME_H:  w_rd = r_cfg.frame_h;
            default:                w_rd = '0;
        endcase
    end

    assign prdata = mbgs_pkg::DATA_W'(w_rd);
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/mbgs_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mirrored-border grid sampler - pipelined mirror fold
// Restoring remainder by the period 2*(n-1), two bits per stage, then the
// sign fix-up and the reflection into [0, n).
// ----------------------------------------------------------------------------
module mbgs_mod (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire  [mbgs_pkg::MAG_W-1:0]   i_mag,
    input  wire                          i_neg,
    input  wire  [mbgs_pkg::CFG_W-1:0]   i_size,
    output logic                         o_valid,
    output logic [mbgs_pkg::CFG_W-1:0]   o_coord
);

    localparam int NS = mbgs_pkg::MOD_STAGES;
    localparam int TW = mbgs_pkg::MOD_TW;
    localparam int BP = mbgs_pkg::MOD_BPS;
    localparam int PW = mbgs_pkg::PER_W;

    logic [PW-1:0]  w_per;
    logic [TW-1:0]  w_mag_pad;

    logic           r_v   [NS];
    logic           r_neg [NS];
    logic [TW-1:0]  r_u   [NS];
    logic [PW-1:0]  r_rem [NS];

    logic           r_fv;
    logic [PW-1:0]  r_m;
    logic           r_ov;
    logic [mbgs_pkg::CFG_W-1:0] r_coord;

    assign w_per     = {i_size - mbgs_pkg::CFG_W'(1), 1'b0};
    assign w_mag_pad = TW'(i_mag);

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic           w_pv;
        logic           w_pneg;
        logic [TW-1:0]  w_pu;
        logic [PW-1:0]  w_prem;
        logic [PW-1:0]  w_rem;

        if (k == 0) begin : g_first
            assign w_pv   = i_valid;
            assign w_pneg = i_neg;
            assign w_pu   = w_mag_pad;
            assign w_prem = '0;
        end else begin : g_next
            assign w_pv   = r_v[k-1];
            assign w_pneg = r_neg[k-1];
            assign w_pu   = r_u[k-1];
            assign w_prem = r_rem[k-1];
        end

        // shift in the next dividend bits, subtract the period where it fits
        always_comb begin
            logic [PW:0] t;
            t     = '0;
            w_rem = w_prem;
            for (int j = 0; j < BP; j++) begin
                t = {w_rem, w_pu[TW-1-k*BP-j]};
                if (t >= {1'b0, w_per}) begin
                    t = t - {1'b0, w_per};
                end
                w_rem = t[PW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= w_pneg;
                r_u[k]   <= w_pu;
                r_rem[k] <= w_rem;
            end
        end
    end

    // fold a negative value back into [0, period)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[NS-1];
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[NS-1] && (r_rem[NS-1] != '0)) begin
                r_m <= w_per - r_rem[NS-1];
            end else begin
                r_m <= r_rem[NS-1];
            end
            if (i_size <= mbgs_pkg::CFG_W'(1)) begin
                r_coord <= '0;
            end else if (r_m < {1'b0, i_size}) begin
                r_coord <= r_m[mbgs_pkg::CFG_W-1:0];
            end else begin
                r_coord <= mbgs_pkg::CFG_W'(w_per - r_m);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_coord = r_coord;

endmodule
`default_nettype wire

// ----- rtl/mbgs_axis.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mirrored-border grid sampler - one axis
// Cell centre to canvas pixel by reciprocal multiply, centring offset, then
// the mirror fold into the frame.
// ----------------------------------------------------------------------------
module mbgs_axis #(
    parameter int GRID = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire  [mbgs_pkg::CELL_W-1:0]  i_cell,
    input  wire  [mbgs_pkg::CFG_W-1:0]   i_canvas,
    input  wire  [mbgs_pkg::CFG_W-1:0]   i_frame,
    output logic                         o_valid,
    output logic [mbgs_pkg::CFG_W-1:0]   o_coord
);

    localparam int PW  = mbgs_pkg::PROD_W;
    localparam int VW  = mbgs_pkg::VAL_W;
    localparam int UW  = mbgs_pkg::MAG_W;
    localparam int OW  = mbgs_pkg::OFF_W;
    localparam int DIV = 2 * GRID;
    localparam int M   = (1 << PW) / DIV;
    localparam int MW  = $clog2(M + 1);
    localparam int QW  = $clog2(((1 << PW) - 1) / DIV + 1);
    localparam int RW  = $clog2(2 * DIV);
    localparam int XW  = PW + MW;

    localparam logic [MW-1:0] M_L   = MW'(M);
    localparam logic [PW-1:0] DIV_P = PW'(DIV);
    localparam logic [RW-1:0] DIV_R = RW'(DIV);

    logic [PW-1:0]         w_p;
    logic [XW-1:0]         w_x;
    logic [PW-1:0]         w_qx;
    logic [PW-1:0]         w_qd;
    logic [PW-1:0]         w_remf;
    logic signed [OW-1:0]  w_d;
    logic signed [OW-1:0]  w_d_adj;
    logic signed [OW-1:0]  w_off;
    logic signed [VW-1:0]  w_v;

    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [PW-1:0]         r_p1, r_p2;
    logic [QW-1:0]         r_q2, r_q3;
    logic [RW-1:0]         r_rem3;
    logic [QW-1:0]         r_c4;
    logic [UW-1:0]         r_mag5;
    logic                  r_neg5;

    assign w_p  = PW'({i_cell, 1'b1}) * PW'(i_canvas);
    assign w_x  = XW'(r_p1) * XW'(M_L);
    assign w_qx = PW'(r_q2);
    assign w_qd = w_qx * DIV_P;
    assign w_remf = r_p2 - w_qd;

    // offset = (canvas - frame) / 2, truncated toward zero
    assign w_d     = $signed({1'b0, i_canvas}) - $signed({1'b0, i_frame});
    assign w_d_adj = w_d + $signed(OW'(w_d[OW-1]));
    assign w_off   = w_d_adj >>> 1;
    assign w_v     = VW'($signed({1'b0, r_c4})) - VW'(w_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= w_p;
            r_p2   <= r_p1;
            r_q2   <= w_x[PW +: QW];
            r_q3   <= r_q2;
            r_rem3 <= w_remf[RW-1:0];
            // estimate is at most one short
            r_c4   <= r_q3 + QW'(r_rem3 >= DIV_R);
            r_neg5 <= w_v[VW-1];
            r_mag5 <= w_v[VW-1] ? UW'(-w_v) : UW'(w_v);
        end
    end

    mbgs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v5),
        .i_mag   (r_mag5),
        .i_neg   (r_neg5),
        .i_size  (i_frame),
        .o_valid (o_valid),
        .o_coord (o_coord)
    );

endmodule
`default_nettype wire

// ----- rtl/mirrored_border_grid_sampler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Mirrored-border grid sampler
// Maps a backdrop grid cell to the mirrored frame pixel that fills it.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the skid entry is empty; the depth
// is set by the 20-bit restoring remainder for the mirror fold, two bits per
// stage over ten stages.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset clears all valid bits and loads sizes 800 x 600 canvas, 640 x 480
// frame; no clearing pass is needed.
module mirrored_border_grid_sampler #(
    parameter int GRID_W  = 64,
    parameter int GRID_H  = 36,
    parameter int MAX_DIM = 4096
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // slave request: [5:0] grid_col, [11:6] grid_row, [15:12] zero
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [15:0]                  s_axis_tdata,
    // master result: [11:0] frame_x, [23:12] frame_y, [47:24] pixel_index
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [47:0]                  m_axis_tdata,
    // master result flag: [0] fill_needed
    output logic                         m_axis_tuser,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [mbgs_pkg::ADDR_W-1:0]  paddr,
    input  wire  [mbgs_pkg::DATA_W-1:0]  pwdata,
    output logic [mbgs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int CW = mbgs_pkg::CFG_W;
    localparam int XY = mbgs_pkg::XY_W;
    localparam int IW = mbgs_pkg::IDX_W;
    localparam int LW = mbgs_pkg::MUL2_W;

    mbgs_pkg::t_cfg  w_cfg;
    logic            w_en;
    logic            w_acc;
    logic            w_xv, w_yv;
    logic [CW-1:0]   w_fx, w_fy;
    logic            w_fill;
    logic [LW-1:0]   w_mul;
    logic [LW-1:0]   w_sum;
    logic            w_push;
    logic            w_pop;
    logic [47:0]     w_res;

    logic            r_ix_valid;
    logic [XY-1:0]   r_fx, r_fy;
    logic [IW-1:0]   r_idx;
    logic            r_fill;
    logic            r_out_valid;
    logic [47:0]     r_out_data;
    logic            r_out_fill;
    logic            r_skid_valid;
    logic [47:0]     r_skid_data;
    logic            r_skid_fill;

    mbgs_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the whole pipe advances unless the skid entry is occupied
    assign w_en          = ~r_skid_valid;
    assign s_axis_tready = ~r_skid_valid;
    assign w_acc         = s_axis_tvalid & s_axis_tready;

    mbgs_axis #(
        .GRID (GRID_W)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_acc),
        .i_cell   (s_axis_tdata[5:0]),
        .i_canvas (w_cfg.canvas_w),
        .i_frame  (w_cfg.frame_w),
        .o_valid  (w_xv),
        .o_coord  (w_fx)
    );

    mbgs_axis #(
        .GRID (GRID_H)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_acc),
        .i_cell   (s_axis_tdata[11:6]),
        .i_canvas (w_cfg.canvas_h),
        .i_frame  (w_cfg.frame_h),
        .o_valid  (w_yv),
        .o_coord  (w_fy)
    );

    assign w_fill = (w_cfg.canvas_w != '0) && (w_cfg.canvas_h != '0) &&
                    (w_cfg.frame_w != '0) && (w_cfg.frame_h != '0) &&
                    !((w_cfg.frame_w >= w_cfg.canvas_w) &&
                      (w_cfg.frame_h >= w_cfg.canvas_h));

    assign w_mul = LW'(w_fy) * LW'(w_cfg.frame_w);
    assign w_sum = w_mul + LW'(w_fx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix_valid <= 1'b0;
        end else if (w_en) begin
            r_ix_valid <= w_xv & w_yv;
        end
    end

    // drop the coordinates when the frame covers the canvas or any size is zero
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fill <= w_fill;
            r_fx   <= w_fill ? w_fx[XY-1:0] : '0;
            r_fy   <= w_fill ? w_fy[XY-1:0] : '0;
            r_idx  <= w_fill ? w_sum[IW-1:0] : '0;
        end
    end

    assign w_res  = {r_idx, r_fy, r_fx};
    assign w_push = w_en & r_ix_valid;
    assign w_pop  = r_out_valid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
                r_out_fill <= r_skid_fill;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_data <= w_res;
                r_skid_fill <= r_fill;
            end else begin
                r_out_data <= w_res;
                r_out_fill <= r_fill;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_fill;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> ($past(r_out_valid) && !$past(m_axis_tready)))
        else $error("skid entry filled while output was free");

    a_axes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xv == w_yv)
        else $error("axis pipelines out of step");

    a_no_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("non-zero coordinates on a covered frame");

endmodule
`default_nettype wire
